### hw/rtl/djb_pkg.sv
// shared types, constants and helpers of the four-lane djb2 hash
package djb_pkg;

  localparam int BYTES_PER_WORD = 8;
  localparam int NUM_LANES      = 4;
  localparam int LANE_W         = 32;
  localparam int WORD_W         = 64;
  localparam int HASH_W         = NUM_LANES * LANE_W;
  localparam int PTR_W          = 2;
  localparam int CNT_W          = 4;
  localparam int CFG_IDX_W      = 8;
  localparam int ROUNDS         = (BYTES_PER_WORD + NUM_LANES - 1) / NUM_LANES;
  localparam int IDX_W          = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;

  localparam logic [LANE_W-1:0] LANE_INIT = LANE_W'(5381);
  localparam logic [CNT_W-1:0]  BPW_CNT   = CNT_W'(BYTES_PER_WORD);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COOKIE_LOW  = CFG_IDX_W'(0),
    REG_COOKIE_HIGH = CFG_IDX_W'(1)
  } cfg_reg_t;

  // per-word control sent to every lane
  typedef struct packed {
    logic             en;
    logic             final_w;
    logic [PTR_W-1:0] ptr;
    logic [CNT_W-1:0] count;
  } lane_ctrl_t;

  // one x33-and-add round
  function automatic logic [LANE_W-1:0] djb_round(input logic [LANE_W-1:0] h,
                                                  input logic [7:0] b);
    djb_round = (h << 5) + h + {{(LANE_W - 8){1'b0}}, b};
  endfunction

endpackage

### hw/rtl/djb_in_if.sv
// input word channel
interface djb_in_if;
  logic                         valid;
  logic                         ready;
  logic [djb_pkg::WORD_W-1:0]   data_word;
  logic [djb_pkg::CNT_W-1:0]    byte_count;
  logic                         final_word;

  modport source (output valid, data_word, byte_count, final_word, input ready);
  modport sink   (input valid, data_word, byte_count, final_word, output ready);
endinterface

### hw/rtl/djb_out_if.sv
// hash result channel
interface djb_out_if;
  logic                         valid;
  logic                         ready;
  logic [djb_pkg::WORD_W-1:0]   hash_half;
  logic                         half_last;

  modport source (output valid, hash_half, half_last, input ready);
  modport sink   (input valid, hash_half, half_last, output ready);
endinterface

### hw/rtl/djb_cfg_if.sv
// configuration write channel
interface djb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [djb_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [djb_pkg::WORD_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### hw/rtl/djb_lane.sv
// one hash lane: absorbs the bytes of a word that fall to it
module djb_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [djb_pkg::PTR_W-1:0]     lane_id,
  input  djb_pkg::lane_ctrl_t           ctrl,
  input  logic [djb_pkg::WORD_W-1:0]    data_word,
  output logic [djb_pkg::LANE_W-1:0]    hash_abs
);

  logic [djb_pkg::LANE_W-1:0] hash_r;
  logic [djb_pkg::LANE_W-1:0] hash_nxt;
  logic [djb_pkg::PTR_W-1:0]  offset;

  assign offset = lane_id - ctrl.ptr;

  // offset + 4r is the byte index within the word
  always_comb begin
    logic [djb_pkg::LANE_W-1:0] h;
    logic [djb_pkg::CNT_W-1:0]  k;
    h = hash_r;
    for (int r = 0; r < djb_pkg::ROUNDS; r++) begin
      k = djb_pkg::CNT_W'(offset) + djb_pkg::CNT_W'(r * djb_pkg::NUM_LANES);
      if (k < ctrl.count) begin
        h = djb_pkg::djb_round(h, data_word[{k[djb_pkg::IDX_W-1:0], 3'b000} +: 8]);
      end
    end
    hash_abs = h;
  end

  always_comb begin
    hash_nxt = hash_r;
    if (ctrl.en) begin
      hash_nxt = ctrl.final_w ? djb_pkg::LANE_INIT : hash_abs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= djb_pkg::LANE_INIT;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

### hw/rtl/djb_merge.sv
// cookie merge and two-half result register
module djb_merge (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        load,
  input  logic [djb_pkg::NUM_LANES-1:0][djb_pkg::LANE_W-1:0] lane_hash,
  input  logic [djb_pkg::HASH_W-1:0]                  cookie,
  output logic                                        slot_free,
  djb_out_if.source                                   out_ch
);

  logic [djb_pkg::HASH_W-1:0] res_r;
  logic [djb_pkg::HASH_W-1:0] res_nxt;
  logic                       valid_r;
  logic                       valid_nxt;
  logic                       half_r;
  logic                       half_nxt;
  logic                       pop;

  assign pop       = valid_r && out_ch.ready;
  assign slot_free = !valid_r || (half_r && out_ch.ready);

  always_comb begin
    res_nxt   = res_r;
    valid_nxt = valid_r;
    half_nxt  = half_r;
    if (load) begin
      res_nxt   = lane_hash ^ cookie;
      valid_nxt = 1'b1;
      half_nxt  = 1'b0;
    end else if (pop) begin
      if (half_r) begin
        valid_nxt = 1'b0;
      end else begin
        half_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.half_last = half_r;
  assign out_ch.hash_half = half_r ? res_r[djb_pkg::HASH_W-1:djb_pkg::WORD_W]
                                   : res_r[djb_pkg::WORD_W-1:0];

endmodule

### hw/rtl/djb2_four_lane_hash_128.sv
// top level of the four-lane interleaved djb2 hash with 128-bit result
//
// usage
// - in_ch carries message words of up to eight bytes, first byte in the low bits,
//   byte_count valid bytes (counts above eight act as eight), final_word on the last
// - all four lanes absorb their share of a word taken on in_ch (two x33-and-add
//   rounds each) in the same cycle, so one word per cycle while no final word waits
// - non-final words are taken every cycle regardless of the result side
// - a final word loads the merge register as it is taken; in the next cycle out_ch
//   shows the low half (lanes 1:0) and, on the next taken cycle, the high half
//   (lanes 3:2) with half_last set
// - a final word waits only while the result register still holds an untaken half;
//   it can be taken in the cycle the previous high half is taken
// - cfg_ch writes cookie_low (index 0) or cookie_high (index 1); other indexes are
//   dropped; cfg_ch is always ready
// - reset (rst_n low, synchronous) sets every lane to 5381, the lane pointer and
//   cookies to zero and drops any pending result
// - when out_ch stalls, the current half holds steady until taken
module djb2_four_lane_hash_128 (
  input  logic       clk,
  input  logic       rst_n,
  djb_in_if.sink     in_ch,
  djb_out_if.source  out_ch,
  djb_cfg_if.sink    cfg_ch
);

  logic [djb_pkg::PTR_W-1:0]   ptr_r;
  logic [djb_pkg::PTR_W-1:0]   ptr_nxt;
  logic [djb_pkg::WORD_W-1:0]  cookie_lo_r;
  logic [djb_pkg::WORD_W-1:0]  cookie_lo_nxt;
  logic [djb_pkg::WORD_W-1:0]  cookie_hi_r;
  logic [djb_pkg::WORD_W-1:0]  cookie_hi_nxt;
  logic [djb_pkg::CNT_W-1:0]   count_sat;
  logic                        slot_free;
  logic                        in_fire;
  djb_pkg::lane_ctrl_t         lane_ctrl;
  logic [djb_pkg::NUM_LANES-1:0][djb_pkg::LANE_W-1:0] lane_abs;

  // final words need a free result slot, others never wait
  assign in_ch.ready = !in_ch.final_word || slot_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // clamp oversize counts to the word size
  assign count_sat = (in_ch.byte_count > djb_pkg::BPW_CNT) ? djb_pkg::BPW_CNT
                                                            : in_ch.byte_count;

  assign lane_ctrl.en      = in_fire;
  assign lane_ctrl.final_w = in_ch.final_word;
  assign lane_ctrl.ptr     = ptr_r;
  assign lane_ctrl.count   = count_sat;

  // lane pointer advances by the byte count, back to lane 0 after a message
  always_comb begin
    ptr_nxt = ptr_r;
    if (in_fire) begin
      ptr_nxt = in_ch.final_word ? '0 : ptr_r + count_sat[djb_pkg::PTR_W-1:0];
    end
  end

  // cookie register writes
  always_comb begin
    cookie_lo_nxt = cookie_lo_r;
    cookie_hi_nxt = cookie_hi_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        djb_pkg::REG_COOKIE_LOW: begin
          cookie_lo_nxt = cfg_ch.wdata;
        end
        djb_pkg::REG_COOKIE_HIGH: begin
          cookie_hi_nxt = cfg_ch.wdata;
        end
        default: begin
          cookie_lo_nxt = cookie_lo_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      cookie_lo_r <= '0;
      cookie_hi_r <= '0;
    end else begin
      ptr_r       <= ptr_nxt;
      cookie_lo_r <= cookie_lo_nxt;
      cookie_hi_r <= cookie_hi_nxt;
    end
  end

  // the lanes, each taking every fourth byte
  for (genvar g = 0; g < djb_pkg::NUM_LANES; g++) begin : g_lane
    djb_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .lane_id   (djb_pkg::PTR_W'(g)),
      .ctrl      (lane_ctrl),
      .data_word (in_ch.data_word),
      .hash_abs  (lane_abs[g])
    );
  end

  // merge: xor with cookies and hand out as two halves
  djb_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire && in_ch.final_word),
    .lane_hash (lane_abs),
    .cookie    ({cookie_hi_r, cookie_lo_r}),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  // a final word shows its low half next cycle
  a_final_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.final_word |=> out_ch.valid && !out_ch.half_last)
    else $error("final word did not load the result register");

  // the high half follows a taken low half
  a_high_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.half_last |=> out_ch.valid && out_ch.half_last)
    else $error("high half missing after low half");

  // the pointer returns to lane 0 after a message
  a_ptr_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.final_word |=> ptr_r == '0)
    else $error("lane pointer not cleared after final word");

  // empty non-final words leave the pointer alone
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_ch.final_word && in_ch.byte_count == '0 |=> $stable(ptr_r))
    else $error("empty word moved the lane pointer");

endmodule

### bench/djb2_four_lane_hash_128_test.sv
// self-checking bench for the four-lane djb2 hash: directed table, then random messages
module djb2_four_lane_hash_128_test;

  // run bounds
  localparam int  CYCLE_LIMIT  = 1_200_000;
  localparam int  PHASE_ITEMS  = 425;
  localparam int  RAND_PHASES  = 4;
  localparam int  SETTLE_CYC   = 8;
  localparam int  MAX_REPORTS  = 10;

  // any index past the two cookie registers is dropped by the block
  localparam logic [djb_pkg::CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = djb_pkg::CFG_IDX_W'(2);

  // hash halves that follow from the lane reset value with zero and all-ones cookies
  localparam logic [djb_pkg::WORD_W-1:0] EMPTY_HALF      = 64'h0000_1505_0000_1505;
  localparam logic [djb_pkg::WORD_W-1:0] EMPTY_HALF_ONES = 64'hFFFF_EAFA_FFFF_EAFA;

  typedef struct {
    logic [djb_pkg::WORD_W-1:0] word;
    logic [djb_pkg::CNT_W-1:0]  cnt;
    logic                       fin;
    bit                         typed;
    logic [djb_pkg::WORD_W-1:0] lo;
    logic [djb_pkg::WORD_W-1:0] hi;
  } stim_row_t;

  typedef struct {
    logic [djb_pkg::WORD_W-1:0] half;
    logic                       last;
  } hash_half_t;

  // directed rows; rows from ONES_ROW on run with both cookies all ones
  localparam int DIR_ROWS = 19;
  localparam int ONES_ROW = 15;
  stim_row_t dir_rows [DIR_ROWS] = '{
    // empty message straight after reset
    '{64'h0, 4'd0, 1'b1, 1'b1, EMPTY_HALF, EMPTY_HALF},
    // single byte extremes, unused bytes of the word clear then set
    '{64'h0000_0000_0000_00FF, 4'd1, 1'b1, 1'b1, 64'h0000_1505_0002_B6A4, EMPTY_HALF},
    '{64'hFFFF_FFFF_FFFF_FF00, 4'd1, 1'b1, 1'b1, 64'h0000_1505_0002_B5A5, EMPTY_HALF},
    // full words of all ones then all zeros
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 64'h0, 64'h0},
    '{64'h0000_0000_0000_0000, 4'd8, 1'b1, 1'b0, 64'h0, 64'h0},
    // count above eight saturates
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b0, 64'h0, 64'h0},
    // odd counts move the lane pointer off zero, empty non-final word in between
    '{64'h0123_4567_89AB_CDEF, 4'd5, 1'b0, 1'b0, 64'h0, 64'h0},
    '{64'hDEAD_BEEF_0BAD_F00D, 4'd9, 1'b0, 1'b0, 64'h0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{64'hA5A5_A5A5_A5A5_A5A5, 4'd3, 1'b1, 1'b0, 64'h0, 64'h0},
    // empty final word after some bytes
    '{64'h8000_0000_0000_0001, 4'd7, 1'b0, 1'b0, 64'h0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b0, 64'h0, 64'h0},
    '{64'h7F7F_7F7F_7F7F_7F7F, 4'd2, 1'b0, 1'b0, 64'h0, 64'h0},
    '{64'h0102_0304_0506_0708, 4'd12, 1'b0, 1'b0, 64'h0, 64'h0},
    '{64'hFEDC_BA98_7654_3210, 4'd1, 1'b1, 1'b0, 64'h0, 64'h0},
    // cookies all ones from here
    '{64'h0, 4'd0, 1'b1, 1'b1, EMPTY_HALF_ONES, EMPTY_HALF_ONES},
    '{64'h5555_5555_5555_5555, 4'd8, 1'b0, 1'b0, 64'h0, 64'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 4'd6, 1'b1, 1'b0, 64'h0, 64'h0},
    '{64'h0000_0000_0000_00FF, 4'd13, 1'b1, 1'b0, 64'h0, 64'h0}
  };

  logic clk;
  logic rst_n;

  djb_in_if  in_ch ();
  djb_out_if out_ch ();
  djb_cfg_if cfg_ch ();

  djb2_four_lane_hash_128 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state: lanes, lane pointer and cookies as the block should hold them
  logic [djb_pkg::LANE_W-1:0] lane_acc [djb_pkg::NUM_LANES];
  logic [djb_pkg::PTR_W-1:0]  lane_ptr;
  logic [djb_pkg::WORD_W-1:0] cookie_lo;
  logic [djb_pkg::WORD_W-1:0] cookie_hi;

  // hash halves predicted but not yet seen on out_ch
  hash_half_t hash_halves_due [$];

  int mismatches;
  int items_sent;
  int cycle_count;
  int in_calm;
  int out_calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("djb2_four_lane_hash_128_test failed");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long, with calm stretches of no gaps
  function automatic int gap_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // clear lanes and pointer to their reset values
  function automatic void lanes_clear();
    for (int i = 0; i < djb_pkg::NUM_LANES; i++) lane_acc[i] = djb_pkg::LANE_INIT;
    lane_ptr = '0;
  endfunction

  // absorb one word into the predicted lanes; on a final word return both halves
  function automatic bit absorb_word(input logic [djb_pkg::WORD_W-1:0] w,
                                     input logic [djb_pkg::CNT_W-1:0] cnt,
                                     input logic fin,
                                     output logic [djb_pkg::WORD_W-1:0] lo,
                                     output logic [djb_pkg::WORD_W-1:0] hi);
    int n;
    n = (cnt > djb_pkg::BPW_CNT) ? djb_pkg::BYTES_PER_WORD : int'(cnt);
    for (int k = 0; k < n; k++) begin
      // x33 plus byte, wraps at 32 bits
      lane_acc[lane_ptr] = lane_acc[lane_ptr] * djb_pkg::LANE_W'(33)
                           + djb_pkg::LANE_W'(w[8*k +: 8]);
      lane_ptr = lane_ptr + 1'b1;
    end
    lo = '0;
    hi = '0;
    if (!fin) return 1'b0;
    lo = {lane_acc[1] ^ cookie_lo[63:32], lane_acc[0] ^ cookie_lo[31:0]};
    hi = {lane_acc[3] ^ cookie_hi[63:32], lane_acc[2] ^ cookie_hi[31:0]};
    lanes_clear();
    return 1'b1;
  endfunction

  // one request on in_ch; the typed halves replace the prediction where given
  task automatic send_word(input logic [djb_pkg::WORD_W-1:0] w,
                           input logic [djb_pkg::CNT_W-1:0] cnt,
                           input logic fin, input bit typed,
                           input logic [djb_pkg::WORD_W-1:0] tlo,
                           input logic [djb_pkg::WORD_W-1:0] thi);
    logic [djb_pkg::WORD_W-1:0] lo;
    logic [djb_pkg::WORD_W-1:0] hi;
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.data_word  <= w;
    in_ch.byte_count <= cnt;
    in_ch.final_word <= fin;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (absorb_word(w, cnt, fin, lo, hi)) begin
      hash_halves_due.push_back('{typed ? tlo : lo, 1'b0});
      hash_halves_due.push_back('{typed ? thi : hi, 1'b1});
    end
    // valid stays up when the next request follows right away
    gap = gap_len(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every predicted half has come out, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (hash_halves_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // one request on cfg_ch, only while the block is idle
  task automatic cfg_write(input logic [djb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [djb_pkg::WORD_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == djb_pkg::REG_COOKIE_LOW) cookie_lo = data;
    else if (idx == djb_pkg::REG_COOKIE_HIGH) cookie_hi = data;
    @(posedge clk);
  endtask

  function automatic logic [djb_pkg::WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // byte count of a non-final word: mostly full, some partial, a little noise
  function automatic logic [djb_pkg::CNT_W-1:0] body_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return djb_pkg::CNT_W'(djb_pkg::BYTES_PER_WORD);
    if (r < 90) return djb_pkg::CNT_W'($urandom_range(1, djb_pkg::BYTES_PER_WORD - 1));
    if (r < 95) return '0;
    return djb_pkg::CNT_W'($urandom_range(djb_pkg::BYTES_PER_WORD + 1, 15));
  endfunction

  // one random message: a few body words and a final word of any count
  task automatic send_message();
    int nbody;
    logic [djb_pkg::CNT_W-1:0] fcnt;
    nbody = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 12);
    for (int i = 0; i < nbody; i++) send_word(rand_word(), body_count(), 1'b0, 1'b0, '0, '0);
    fcnt = ($urandom_range(0, 9) == 0)
           ? djb_pkg::CNT_W'($urandom_range(9, 15))
           : djb_pkg::CNT_W'($urandom_range(0, djb_pkg::BYTES_PER_WORD));
    send_word(rand_word(), fcnt, 1'b1, 1'b0, '0, '0);
  endtask

  // cookie pair for a random phase: extremes on the first ones, random later
  task automatic phase_cookies(input int p);
    case (p)
      0: begin
        cfg_write(djb_pkg::REG_COOKIE_LOW, '1);
        cfg_write(djb_pkg::REG_COOKIE_HIGH, '0);
      end
      1: begin
        cfg_write(djb_pkg::REG_COOKIE_LOW, '0);
        cfg_write(djb_pkg::REG_COOKIE_HIGH, '1);
      end
      default: begin
        cfg_write(djb_pkg::REG_COOKIE_LOW, rand_word());
        cfg_write(djb_pkg::REG_COOKIE_HIGH, rand_word());
      end
    endcase
    // a write to an unmapped index must leave the cookies alone
    cfg_write(djb_pkg::CFG_IDX_W'($urandom_range(int'(REG_FIRST_UNMAPPED), 255)),
              rand_word());
  endtask

  // result side: bursts of ready with random stalls in between
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = gap_len(out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // result checker: every half against the oldest prediction
  always @(posedge clk) begin
    hash_half_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hash_halves_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected hash half %h last %b", out_ch.hash_half, out_ch.half_last);
      end else begin
        due = hash_halves_due.pop_front();
        if (out_ch.hash_half !== due.half || out_ch.half_last !== due.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("hash half mismatch: expected %h last %b, got %h last %b",
                     due.half, due.last, out_ch.hash_half, out_ch.half_last);
        end
      end
    end
  end

  // stimulus
  initial begin
    mismatches  = 0;
    items_sent  = 0;
    cycle_count = 0;
    in_calm     = 0;
    out_calm    = 0;
    cookie_lo   = '0;
    cookie_hi   = '0;
    lanes_clear();

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_word  <= '0;
    in_ch.byte_count <= '0;
    in_ch.final_word <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= djb_pkg::REG_COOKIE_LOW;
    cfg_ch.wdata     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reset cookies first, then all ones
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == ONES_ROW) begin
        drain();
        cfg_write(djb_pkg::REG_COOKIE_LOW, '1);
        cfg_write(djb_pkg::REG_COOKIE_HIGH, '1);
      end
      send_word(dir_rows[i].word, dir_rows[i].cnt, dir_rows[i].fin, dir_rows[i].typed,
                dir_rows[i].lo, dir_rows[i].hi);
    end

    // random messages over several cookie settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      phase_cookies(p);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        send_message();
        // now and then hold off until the block has emptied
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    if (mismatches == 0 && hash_halves_due.size() == 0) begin
      $display("djb2_four_lane_hash_128_test passed");
    end else begin
      $display("djb2_four_lane_hash_128_test failed");
    end
    $finish;
  end

endmodule
